[src/wrsp_pkg.sv]
// Shared types and constants for the RIFF wave stream parser.
`default_nettype none
package wrsp_pkg;

  // Parse phases of the byte stream.
  typedef enum logic [2:0] {
    PH_RIFF = 3'd0,
    PH_HEAD = 3'd1,
    PH_FMT  = 3'd2,
    PH_FACT = 3'd3,
    PH_DATA = 3'd4
  } phase_e;

  // Result kinds.
  typedef enum logic [2:0] {
    K_SAMPLE = 3'd0,
    K_FORMAT = 3'd1,
    K_FACT   = 3'd2,
    K_ERROR  = 3'd3,
    K_EOF    = 3'd4
  } kind_e;

  // Chunk identifiers, little-endian, lower case.
  localparam logic [31:0] TagFmt  = 32'h2074_6d66;
  localparam logic [31:0] TagData = 32'h6174_6164;
  localparam logic [31:0] TagFact = 32'h7463_6166;

  localparam logic [31:0] FmtMinLen   = 32'd16;
  localparam logic [31:0] FactMinLen  = 32'd12;
  localparam logic [31:0] RiffHdrLen  = 32'd12;
  localparam logic [31:0] ChunkHdrLen = 32'd8;

  // Result queue depth.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    kind_e       kind;
    logic        channel;
    logic [15:0] sample_value;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [15:0] extra_word;
    logic [31:0] info_word;
    logic        last;
  } out_t;

  // Results of one item, packed to the low slots.
  typedef struct packed {
    logic [1:0] count;
    out_t       r1;
    out_t       r0;
  } push_t;

endpackage
`default_nettype wire

[src/wrsp_front.sv]
// Front end: parses one byte per item and produces up to two results.
`default_nettype none
module wrsp_front import wrsp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  accept_i,
  input  wire in_t   item_i,
  output push_t      push_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d, tag_q, tag_d, len_q, len_d, riff_q, riff_d;
  logic [63:0] fmtf_q, fmtf_d, ratef_q, ratef_d;
  logic [15:0] extra_q, extra_d;
  logic [31:0] fact_q, fact_d, frames_q, frames_d;
  logic [7:0]  low_q, low_d;
  logic        bis_q, bis_d, ch_q, ch_d, err_q, err_d, stop_q, stop_d;

  // Next state and results of the accepted byte.
  always_comb begin
    logic [31:0] inc;
    logic [7:0]  b, lb;
    logic [15:0] chans, bits;
    logic [1:0]  shift;
    logic        p_emit;
    kind_e       p_kind;
    logic        p_ch;
    logic [15:0] p_val;
    logic [31:0] p_info;
    out_t        rp, re;
    b = item_i.data_byte;
    if (item_i.first_byte) begin
      phase_d = PH_RIFF; cnt_d = '0; tag_d = '0; len_d = '0; riff_d = '0;
      fmtf_d = '0; ratef_d = '0; extra_d = '0; fact_d = '0; frames_d = '0;
      low_d = '0; bis_d = 1'b0; ch_d = 1'b0; err_d = 1'b0; stop_d = 1'b0;
    end else begin
      phase_d = phase_q; cnt_d = cnt_q; tag_d = tag_q; len_d = len_q; riff_d = riff_q;
      fmtf_d = fmtf_q; ratef_d = ratef_q; extra_d = extra_q; fact_d = fact_q;
      frames_d = frames_q; low_d = low_q; bis_d = bis_q; ch_d = ch_q;
      err_d = err_q; stop_d = stop_q;
    end
    inc = cnt_d + 32'd1;
    lb = (b inside {[8'h41:8'h5A]}) ? b + 8'd32 : b;
    chans = fmtf_d[31:16];
    bits = fmtf_d[63:48];
    shift = '0;
    p_emit = 1'b0; p_kind = K_SAMPLE; p_ch = 1'b0; p_val = '0; p_info = '0;
    if (!stop_d && !err_d) begin
      case (phase_d)
        PH_RIFF: begin
          if (cnt_d >= 32'd4 && cnt_d < 32'd8) riff_d[cnt_d[1:0]*8 +: 8] = b;
          cnt_d = inc;
          if (inc == RiffHdrLen) begin
            phase_d = PH_HEAD; cnt_d = '0;
          end
        end
        PH_HEAD: begin
          if (cnt_d < 32'd4) tag_d[cnt_d[1:0]*8 +: 8] = lb;
          else len_d[cnt_d[1:0]*8 +: 8] = b;
          cnt_d = inc;
          if (inc == ChunkHdrLen) begin
            cnt_d = '0;
            if (tag_d == TagFmt) begin
              if (len_d < FmtMinLen) begin
                err_d = 1'b1; p_emit = 1'b1; p_kind = K_ERROR;
              end else begin
                extra_d = '0; phase_d = PH_FMT;
              end
            end else if (tag_d == TagFact) begin
              if (len_d < FactMinLen) begin
                err_d = 1'b1; p_emit = 1'b1; p_kind = K_ERROR;
              end else begin
                fact_d = '0; phase_d = PH_FACT;
              end
            end else if (tag_d == TagData) begin
              if ((bits != 16'd8 && bits != 16'd16) || (chans != 16'd1 && chans != 16'd2)) begin
                err_d = 1'b1; p_emit = 1'b1; p_kind = K_ERROR;
              end else begin
                // Frame size is 1, 2 or 4 bytes, so the divide is a shift.
                shift = {1'b0, chans == 16'd2} + {1'b0, bits == 16'd16};
                frames_d = len_d >> shift;
                bis_d = 1'b0; ch_d = 1'b0; low_d = '0;
                phase_d = (len_d == '0) ? PH_HEAD : PH_DATA;
              end
            end else begin
              stop_d = 1'b1;
            end
          end
        end
        PH_FMT: begin
          if (cnt_d < 32'd4) fmtf_d[cnt_d[2:0]*8 +: 8] = b;
          else if (cnt_d < 32'd12) ratef_d[3'(cnt_d - 32'd4)*8 +: 8] = b;
          else if (cnt_d < 32'd16) fmtf_d[3'(cnt_d - 32'd8)*8 +: 8] = b;
          else if (cnt_d == 32'd16) extra_d[7:0] = b;
          else if (cnt_d == 32'd17) extra_d[15:8] = b;
          cnt_d = inc;
          if (inc == len_d) begin
            p_emit = 1'b1; p_kind = K_FORMAT; phase_d = PH_HEAD; cnt_d = '0;
          end
        end
        PH_FACT: begin
          if (cnt_d >= 32'd8 && cnt_d < 32'd12) fact_d[cnt_d[1:0]*8 +: 8] = b;
          cnt_d = inc;
          if (inc == len_d) begin
            p_emit = 1'b1; p_kind = K_FACT; p_info = fact_d;
            phase_d = PH_HEAD; cnt_d = '0;
          end
        end
        PH_DATA: begin
          if (frames_d != '0) begin
            if (bits == 16'd8) begin
              p_emit = 1'b1; p_val = {8'd0, b};
            end else if (!bis_d) begin
              low_d = b; bis_d = 1'b1;
            end else begin
              p_emit = 1'b1; p_val = {b, low_d}; bis_d = 1'b0;
            end
            if (p_emit) begin
              p_ch = ch_d;
              if (chans == 16'd2 && !ch_d) ch_d = 1'b1;
              else begin
                ch_d = 1'b0; frames_d = frames_d - 32'd1;
              end
            end
          end
          cnt_d = inc;
          if (inc == len_d) begin
            phase_d = PH_HEAD; cnt_d = '0;
          end
        end
        default: stop_d = 1'b1;
      endcase
    end
    // Parse result.
    rp = '0;
    rp.kind = p_kind;
    rp.channel = p_ch;
    rp.sample_value = p_val;
    rp.info_word = p_info;
    if (p_kind == K_FORMAT) begin
      rp.format_tag = fmtf_d[15:0];
      rp.channel_count = fmtf_d[31:16];
      rp.block_align = fmtf_d[47:32];
      rp.bits_per_sample = fmtf_d[63:48];
      rp.sample_rate = ratef_d[31:0];
      rp.byte_rate = ratef_d[63:32];
      rp.extra_word = extra_d;
    end
    // End-of-file result.
    re = '0;
    re.kind = K_EOF;
    re.info_word = riff_d + 32'd8;
    re.last = 1'b1;
    if (item_i.last_byte) stop_d = 1'b1;
    rp.last = !item_i.last_byte;
    push_o.r0 = p_emit ? rp : re;
    push_o.r1 = re;
    push_o.count = {1'b0, p_emit} + {1'b0, item_i.last_byte};
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF; cnt_q <= '0; tag_q <= '0; len_q <= '0; riff_q <= '0;
      fmtf_q <= '0; ratef_q <= '0; extra_q <= '0; fact_q <= '0; frames_q <= '0;
      low_q <= '0; bis_q <= 1'b0; ch_q <= 1'b0; err_q <= 1'b0; stop_q <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d; cnt_q <= cnt_d; tag_q <= tag_d; len_q <= len_d;
      riff_q <= riff_d; fmtf_q <= fmtf_d; ratef_q <= ratef_d; extra_q <= extra_d;
      fact_q <= fact_d; frames_q <= frames_d; low_q <= low_d; bis_q <= bis_d;
      ch_q <= ch_d; err_q <= err_d; stop_q <= stop_d;
    end
  end

endmodule
`default_nettype wire

[src/wrsp_queue.sv]
// Back end: result queue that takes up to two items a cycle and drives the output.
`default_nettype none
module wrsp_queue import wrsp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_en_i,
  input  wire push_t push_i,
  output logic       space_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_t       out_data_o
);

  out_t            mem_q [QDepth];
  logic [QAw-1:0]  wp_q, rp_q;
  logic [QAw:0]    cnt_q;
  logic [1:0]      nin;
  logic            pop;

  assign nin = push_en_i ? push_i.count : 2'd0;
  assign pop = out_valid_o && out_ready_i;
  assign out_valid_o = cnt_q != '0;
  assign out_data_o = mem_q[rp_q];
  // Room for the two results one item can cause.
  assign space_o = cnt_q <= (QAw+1)'(QDepth - 2);

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (nin != 2'd0) mem_q[wp_q] <= push_i.r0;
    if (nin == 2'd2) mem_q[wp_q + QAw'(1)] <= push_i.r1;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q <= wp_q + QAw'(nin);
      if (pop) rp_q <= rp_q + QAw'(1);
      cnt_q <= cnt_q + (QAw+1)'(nin) - (QAw+1)'(pop);
    end
  end

endmodule
`default_nettype wire

[src/riff_wave_stream_parser_unit.sv]
// A result is written to the queue when its byte is accepted and reaches the output behind older results.
// Throughput: one byte per cycle while the queue has room for two results; a byte with last_byte may queue two results.
// The rate is set by the parser, which updates its state on each accepted byte, and the four-entry queue.
// Reset (rst_ni low, asynchronous) clears the parser to the RIFF header phase
// and empties the queue.
// Top level of the RIFF wave stream parser.
`default_nettype none
module riff_wave_stream_parser_unit import wrsp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  push_t push;
  logic  accept;

  assign accept = in_valid_i && in_ready_o;

  // Byte parser.
  wrsp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .push_o   (push)
  );

  // Result queue and output.
  wrsp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_en_i   (accept),
    .push_i      (push),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

[src/wrsp_checker.sv]
// Port checker for the RIFF wave stream parser, bound to the top level.
`default_nettype none
module wrsp_checker import wrsp_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic out_valid_o,
  input wire logic out_ready_i,
  input wire out_t out_data_o
);

  // A stalled item holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  // End of file always closes the results of its byte.
  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == K_EOF |-> out_data_o.last)
    else $error("end of file item without last");

  // Only format items carry format fields.
  a_fmt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind != K_FORMAT |->
      out_data_o.format_tag == '0 && out_data_o.sample_rate == '0 &&
      out_data_o.bits_per_sample == '0)
    else $error("format fields on non-format item");

endmodule

bind riff_wave_stream_parser_unit wrsp_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
